### rtl/polygon_backface_cull_top_defines.svh
// ----------------------------------------------------------------------------
// polygon_backface_cull_top_defines.svh
// assertion macros shared by the back-face cull modules
// ----------------------------------------------------------------------------
`ifndef POLYGON_BACKFACE_CULL_TOP_DEFINES_SVH
`define POLYGON_BACKFACE_CULL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfc assertion failed");

// next-cycle implication, checked out of reset
`define BFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfc assertion failed");

`endif

### rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// widths, register indexes and shared types of the back-face cull block
// ----------------------------------------------------------------------------
package bfc_pkg;

  // polygon size limit
  localparam int MAX_POINTS = 8;
  localparam int AXES       = 3;

  // field widths
  localparam int POS_W     = 24;
  localparam int NRM_W     = 16;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int POS_SUM_W = POS_W + $clog2(MAX_POINTS);
  localparam int NRM_SUM_W = NRM_W + $clog2(MAX_POINTS);
  localparam int DIFF_W    = POS_SUM_W + 1;
  localparam int PROD_W    = DIFF_W + NRM_SUM_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  // running sums of one polygon
  typedef struct packed {
    logic [AXES-1:0][POS_SUM_W-1:0] pos;
    logic [AXES-1:0][NRM_SUM_W-1:0] nrm;
    logic [CNT_W-1:0]               count;
    logic                           overflow;
  } bfc_sums_t;

endpackage

### rtl/bfc_accum.sv
// ----------------------------------------------------------------------------
// bfc_accum
// sums vertex positions and normals, counts points, flags overflow
// ----------------------------------------------------------------------------
module bfc_accum (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        vertex_req_i,
  input  logic [bfc_pkg::AXES-1:0][bfc_pkg::POS_W-1:0] position_i,
  input  logic [bfc_pkg::AXES-1:0][bfc_pkg::NRM_W-1:0] normal_i,
  input  logic                                        clear_i,
  output bfc_pkg::bfc_sums_t                          sums_o
);
  import bfc_pkg::*;

  `include "polygon_backface_cull_top_defines.svh"

  bfc_sums_t sums_q, sums_d;
  logic      has_room;

  // room left for another point
  assign has_room = sums_q.count < CNT_W'(MAX_POINTS);

  // clear wins; else add one vertex unless the polygon is already full, which flags overflow
  always_comb begin
    sums_d = sums_q;
    if (clear_i) begin
      sums_d = '0;
    end else if (vertex_req_i) begin
      if (has_room) begin
        for (int i = 0; i < AXES; i++) begin
          sums_d.pos[i] = sums_q.pos[i]
                        + {{(POS_SUM_W-POS_W){position_i[i][POS_W-1]}}, position_i[i]};
          sums_d.nrm[i] = sums_q.nrm[i]
                        + {{(NRM_SUM_W-NRM_W){normal_i[i][NRM_W-1]}}, normal_i[i]};
        end
        sums_d.count = sums_q.count + CNT_W'(1);
      end else begin
        sums_d.overflow = 1'b1;
      end
    end
  end

  // sum registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

  `BFC_ASSERT_IMP(a_count_bound, 1'b1, sums_q.count <= CNT_W'(MAX_POINTS))
  `BFC_ASSERT_NXT(a_clear_empty, clear_i, (sums_q.count == '0) && !sums_q.overflow)
  `BFC_ASSERT_NXT(a_overflow_full, vertex_req_i && has_room && !sums_q.overflow, !sums_q.overflow)

endmodule

### rtl/bfc_dot.sv
// ----------------------------------------------------------------------------
// bfc_dot
// sequencer around one shared multiplier: dot(nrm_sum, pos_sum - n*camera)
// ----------------------------------------------------------------------------
module bfc_dot (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic                                        skip_i,
  input  bfc_pkg::bfc_sums_t                          sums_i,
  input  logic [bfc_pkg::AXES-1:0][bfc_pkg::POS_W-1:0] camera_i,
  input  logic                                        out_free_i,
  output logic                                        busy_o,
  output logic                                        done_o,
  output logic                                        culled_o
);
  import bfc_pkg::*;

  `include "polygon_backface_cull_top_defines.svh"

  localparam int AXIS_W = $clog2(AXES);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAM  = 3'd1;
  localparam logic [2:0] ST_DOT  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [AXIS_W-1:0]        axis_q, axis_d;
  logic                     skip_q, skip_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] mul_q, mul_d;

  logic [POS_SUM_W-1:0]        pos_sel;
  logic [NRM_SUM_W-1:0]        nrm_sel;
  logic [POS_W-1:0]            cam_sel;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [DIFF_W-1:0]    mul_a;
  logic signed [NRM_SUM_W-1:0] mul_b;
  logic signed [PROD_W-1:0]    prod;

  // operands of the current axis
  assign pos_sel = sums_i.pos[axis_q];
  assign nrm_sel = sums_i.nrm[axis_q];
  assign cam_sel = camera_i[axis_q];
  assign diff    = $signed({pos_sel[POS_SUM_W-1], pos_sel}) - $signed(mul_q[DIFF_W-1:0]);

  // shared multiplier: n*camera first, then normal*difference
  always_comb begin
    if (state_q == ST_CAM) begin
      mul_a = $signed({{(DIFF_W-POS_W){cam_sel[POS_W-1]}}, cam_sel});
      mul_b = $signed({{(NRM_SUM_W-CNT_W){1'b0}}, sums_i.count});
    end else begin
      mul_a = diff;
      mul_b = $signed(nrm_sel);
    end
  end

  assign prod = mul_a * mul_b;

  // step sequencer
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    skip_d  = skip_q;
    acc_d   = acc_q;
    mul_d   = mul_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CAM;
          axis_d  = '0;
          skip_d  = skip_i;
          acc_d   = '0;
        end
      end
      ST_CAM: begin
        mul_d   = prod;
        state_d = ST_DOT;
      end
      ST_DOT: begin
        mul_d   = prod;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + ACC_W'(mul_q);
        if (axis_q == AXIS_W'(AXES - 1)) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = ST_CAM;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      skip_q  <= skip_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mul_q <= mul_d;
  end

  // status and verdict
  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_DONE) && out_free_i;
  assign culled_o = !skip_q && !sums_i.overflow && !acc_q[ACC_W-1] && (acc_q != '0);

  `BFC_ASSERT_IMP(a_start_idle, start_i, state_q == ST_IDLE)
  `BFC_ASSERT_NXT(a_start_cam, start_i, state_q == ST_CAM)
  `BFC_ASSERT_IMP(a_axis_range, busy_o, axis_q <= AXIS_W'(AXES - 1))

endmodule

### rtl/polygon_backface_cull_top.sv
// a vertex that does not end its polygon is taken back to back while the dot sequencer is idle
// the last vertex starts a dot product on one shared multiplier; per axis the sequencer
// steps through ST_CAM (n*camera), ST_DOT (normal*difference) and ST_ACC, then ST_DONE
// moves the result to the output register once that is free; until then input is held
// reset (asynchronous, active low) clears the camera to zero and empties the vertex sums
// ----------------------------------------------------------------------------
// polygon_backface_cull_top
// back-face test of vertex-streamed polygons against a configurable camera
// ----------------------------------------------------------------------------
module polygon_backface_cull_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // vertex channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfc_pkg::POS_W-1:0]       vertex_x_i,
  input  logic [bfc_pkg::POS_W-1:0]       vertex_y_i,
  input  logic [bfc_pkg::POS_W-1:0]       vertex_z_i,
  input  logic [bfc_pkg::NRM_W-1:0]       normal_x_i,
  input  logic [bfc_pkg::NRM_W-1:0]       normal_y_i,
  input  logic [bfc_pkg::NRM_W-1:0]       normal_z_i,
  input  logic                            last_point_i,
  input  logic                            skip_cull_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            culled_o,
  output logic                            too_many_points_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfc_pkg::POS_W-1:0]       cfg_data_i
);
  import bfc_pkg::*;

  logic [AXES-1:0][POS_W-1:0] camera_q;
  logic [AXES-1:0][POS_W-1:0] position;
  logic [AXES-1:0][NRM_W-1:0] normal;
  bfc_sums_t                  sums;
  logic                       vertex_req;
  logic                       start;
  logic                       dot_busy;
  logic                       dot_done;
  logic                       dot_culled;
  logic                       out_free;
  logic                       out_valid_q;
  logic                       culled_q;
  logic                       too_many_q;

  // camera registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CAMERA_X: camera_q[0] <= cfg_data_i;
        CFG_CAMERA_Y: camera_q[1] <= cfg_data_i;
        CFG_CAMERA_Z: camera_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_ready_o = !dot_busy;
  assign vertex_req = in_valid_i && in_ready_o;
  assign start      = vertex_req && last_point_i;
  assign position   = {vertex_z_i, vertex_y_i, vertex_x_i};
  assign normal     = {normal_z_i, normal_y_i, normal_x_i};

  bfc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vertex_req_i (vertex_req),
    .position_i   (position),
    .normal_i     (normal),
    .clear_i      (dot_done),
    .sums_o       (sums)
  );

  bfc_dot u_dot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .skip_i     (skip_cull_i),
    .sums_i     (sums),
    .camera_i   (camera_q),
    .out_free_i (out_free),
    .busy_o     (dot_busy),
    .done_o     (dot_done),
    .culled_o   (dot_culled)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dot_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dot_done) begin
      culled_q   <= dot_culled;
      too_many_q <= sums.overflow;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign culled_o          = culled_q;
  assign too_many_points_o = too_many_q;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertex-stream back-face cull block: a local
// predictor accumulates every accepted vertex, builds the expected verdict on
// each polygon end, and a monitor compares every result request against it
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfc_pkg::*;

  // field extremes and handy fixed-point ones
  localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));
  localparam int NRM_MAX = 2 ** (NRM_W - 1) - 1;
  localparam int NRM_MIN = -(2 ** (NRM_W - 1));
  localparam int POS_ONE = 256;
  localparam int NRM_ONE = 16384;
  // cycles allowed for a dot product still in flight after the last verdict
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    last;
    logic                    skip;
  } vertex_t;

  typedef struct packed {
    logic culled;
    logic too_many;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [POS_W-1:0]     vertex_x_i = '0;
  logic [POS_W-1:0]     vertex_y_i = '0;
  logic [POS_W-1:0]     vertex_z_i = '0;
  logic [NRM_W-1:0]     normal_x_i = '0;
  logic [NRM_W-1:0]     normal_y_i = '0;
  logic [NRM_W-1:0]     normal_z_i = '0;
  logic                 last_point_i = 1'b0;
  logic                 skip_cull_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 culled_o;
  logic                 too_many_points_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_CAMERA_X;
  logic [POS_W-1:0]     cfg_data_i = '0;

  // predictor state: camera, running sums and the pending verdicts
  longint   camera_pos[3];
  longint   pos_acc[3];
  longint   nrm_acc[3];
  int       vertex_total;
  bit       overflow_seen;
  verdict_t verdict_q[$];

  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;

  polygon_backface_cull_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .vertex_x_i        (vertex_x_i),
    .vertex_y_i        (vertex_y_i),
    .vertex_z_i        (vertex_z_i),
    .normal_x_i        (normal_x_i),
    .normal_y_i        (normal_y_i),
    .normal_z_i        (normal_z_i),
    .last_point_i      (last_point_i),
    .skip_cull_i       (skip_cull_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .culled_o          (culled_o),
    .too_many_points_o (too_many_points_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // compare each result request with the oldest pending verdict
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no polygon pending");
      end else begin
        want = verdict_q.pop_front();
        if (culled_o !== want.culled)
          report_mismatch($sformatf("culled got %b want %b", culled_o, want.culled));
        if (too_many_points_o !== want.too_many)
          report_mismatch($sformatf("too_many_points got %b want %b",
                                    too_many_points_o, want.too_many));
      end
    end
  end

  // fold one accepted vertex into the sums, verdict on the polygon end
  task automatic accumulate_vertex(input vertex_t v);
    longint   n;
    longint   dx;
    longint   dy;
    longint   dz;
    longint   dot;
    verdict_t verdict;
    if (vertex_total < MAX_POINTS) begin
      pos_acc[0] = pos_acc[0] + $signed(v.x);
      pos_acc[1] = pos_acc[1] + $signed(v.y);
      pos_acc[2] = pos_acc[2] + $signed(v.z);
      nrm_acc[0] = nrm_acc[0] + $signed(v.nx);
      nrm_acc[1] = nrm_acc[1] + $signed(v.ny);
      nrm_acc[2] = nrm_acc[2] + $signed(v.nz);
      vertex_total++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (v.last) begin
      verdict.culled   = 1'b0;
      verdict.too_many = overflow_seen;
      if (!overflow_seen && !v.skip) begin
        n   = vertex_total;
        dx  = pos_acc[0] - n * camera_pos[0];
        dy  = pos_acc[1] - n * camera_pos[1];
        dz  = pos_acc[2] - n * camera_pos[2];
        dot = nrm_acc[0] * dx + nrm_acc[1] * dy + nrm_acc[2] * dz;
        verdict.culled = (dot > 0);
      end
      verdict_q.push_back(verdict);
      for (int a = 0; a < 3; a++) begin
        pos_acc[a] = 0;
        nrm_acc[a] = 0;
      end
      vertex_total  = 0;
      overflow_seen = 1'b0;
    end
  endtask

  // one vertex request, with an optional gap ahead of it
  task automatic send_vertex(input vertex_t v);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    vertex_x_i   <= v.x;
    vertex_y_i   <= v.y;
    vertex_z_i   <= v.z;
    normal_x_i   <= v.nx;
    normal_y_i   <= v.ny;
    normal_z_i   <= v.nz;
    last_point_i <= v.last;
    skip_cull_i  <= v.skip;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_vertex(v);
  endtask

  // stop sending and let every pending polygon finish
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_camera(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [POS_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CAMERA_X: camera_pos[0] = value;
      CFG_CAMERA_Y: camera_pos[1] = value;
      CFG_CAMERA_Z: camera_pos[2] = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_camera(input logic signed [POS_W-1:0] cx,
                            input logic signed [POS_W-1:0] cy,
                            input logic signed [POS_W-1:0] cz);
    wait_for_idle();
    write_camera(CFG_CAMERA_X, cx);
    write_camera(CFG_CAMERA_Y, cy);
    write_camera(CFG_CAMERA_Z, cz);
  endtask

  function automatic vertex_t make_vertex(input int x, input int y, input int z,
                                          input int nx, input int ny, input int nz,
                                          input bit last, input bit skip);
    vertex_t v;
    v.x    = x[POS_W-1:0];
    v.y    = y[POS_W-1:0];
    v.z    = z[POS_W-1:0];
    v.nx   = nx[NRM_W-1:0];
    v.ny   = ny[NRM_W-1:0];
    v.nz   = nz[NRM_W-1:0];
    v.last = last;
    v.skip = skip;
    return v;
  endfunction

  // polygon of random vertices; skip flag random on non-last vertices
  task automatic send_random_polygon(input int size, input bit skip_last);
    vertex_t v;
    for (int i = 0; i < size; i++) begin
      v.x    = POS_W'($urandom);
      v.y    = POS_W'($urandom);
      v.z    = POS_W'($urandom);
      v.nx   = NRM_W'($urandom);
      v.ny   = NRM_W'($urandom);
      v.nz   = NRM_W'($urandom);
      v.last = (i == size - 1);
      v.skip = v.last ? skip_last : 1'($urandom_range(1));
      send_vertex(v);
    end
  endtask

  // triangle in front of a camera at the origin, normal pointing away
  task automatic test_facing_away();
    send_vertex(make_vertex(0, 0, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b0, 1'b1));
    send_vertex(make_vertex(POS_ONE, 0, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b0, 1'b0));
    send_vertex(make_vertex(0, POS_ONE, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b1, 1'b0));
  endtask

  // same triangle, skip on the last vertex forces a keep
  task automatic test_skip_cull();
    send_vertex(make_vertex(0, 0, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b0, 1'b0));
    send_vertex(make_vertex(POS_ONE, 0, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b0, 1'b0));
    send_vertex(make_vertex(0, POS_ONE, 10 * POS_ONE, 0, 0, NRM_ONE, 1'b1, 1'b1));
  endtask

  // one-vertex polygon with zero dot, then a two-vertex polygon facing away
  task automatic test_short_polygons();
    send_vertex(make_vertex(0, 0, 0, NRM_ONE, 0, 0, 1'b1, 1'b0));
    send_vertex(make_vertex(-3 * POS_ONE, POS_ONE, 0, -NRM_ONE, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(-3 * POS_ONE, 0, POS_ONE, -NRM_ONE, 0, 0, 1'b1, 1'b0));
  endtask

  // full polygon of extreme fields against a camera at the minimum corner
  task automatic test_extremes();
    set_camera(POS_W'(POS_MIN), POS_W'(POS_MIN), POS_W'(POS_MIN));
    for (int i = 0; i < MAX_POINTS; i++)
      send_vertex(make_vertex(POS_MAX, POS_MAX, POS_MAX, NRM_MIN, NRM_MIN, NRM_MIN,
                              i == MAX_POINTS - 1, i[0]));
  endtask

  // one vertex beyond the limit, camera at the maximum corner
  task automatic test_overflow();
    set_camera(POS_W'(POS_MAX), POS_W'(POS_MAX), POS_W'(POS_MAX));
    for (int i = 0; i <= MAX_POINTS; i++)
      send_vertex(make_vertex(POS_MIN, POS_MIN, POS_MIN, NRM_MAX, NRM_MAX, NRM_MAX,
                              i == MAX_POINTS, 1'b0));
  endtask

  // random polygons, mostly legal sizes, some beyond the limit
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int vertices, input int cx, input int cy,
                                     input int cz);
    int sent;
    int size;
    set_camera(cx[POS_W-1:0], cy[POS_W-1:0], cz[POS_W-1:0]);
    sender_idle_pct    = sender_idle;
    receiver_stall_pct = receiver_stall;
    sent = 0;
    while (sent < vertices) begin
      if ($urandom_range(99) < 12)
        size = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
      else
        size = $urandom_range(1, MAX_POINTS);
      send_random_polygon(size, $urandom_range(99) < 20);
      sent += size;
    end
    wait_for_idle();
  endtask

  // run guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("polygon_backface_cull_top verification failed");
    $finish;
  end

  // test sequence
  initial begin
    for (int a = 0; a < 3; a++) begin
      camera_pos[a] = 0;
      pos_acc[a]    = 0;
      nrm_acc[a]    = 0;
    end
    vertex_total  = 0;
    overflow_seen = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_facing_away();
    test_skip_cull();
    test_short_polygons();
    test_extremes();
    test_overflow();
    test_random_traffic(21, 71, 250, $urandom, $urandom, $urandom);
    test_random_traffic(71, 21, 250, POS_MAX, POS_MIN, 0);
    test_random_traffic(0, 0, 250, $urandom, $urandom, $urandom);

    if (mismatch_count == 0) begin
      $display("polygon_backface_cull_top verification clean");
    end else begin
      $display("polygon_backface_cull_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bfc_pkg.sv
rtl/bfc_accum.sv
rtl/bfc_dot.sv
rtl/polygon_backface_cull_top.sv
sim/tb_top.sv
